### hdl/fdsp_pkg.sv
// ----------------------------------------------------------------------------
// fdsp_pkg
// Shared constants and types for the flux data separator PLL.
// ----------------------------------------------------------------------------
package fdsp_pkg;

    localparam int BIT_COUNT_WIDTH_DEF = 24;

    // Field widths
    localparam int CELL_W    = 10;
    localparam int BUDGET_W  = 24;
    localparam int FLUX_W    = 16;
    localparam int ZRUN_W    = 17;
    localparam int PERIOD_W  = 15;
    localparam int PHASE_W   = 22;
    localparam int POS_W     = PHASE_W + 1;
    localparam int QUOT_W    = 24;
    localparam int CFG_IDX_W = 1;

    // Intervals and periods are kept in 1/16 tick units
    localparam int SCALE_SHIFT = 4;
    localparam int GAIN_SHIFT  = 2;

    localparam logic [CELL_W-1:0]   CELL_TIME_RESET  = 10'd48;
    localparam logic [BUDGET_W-1:0] BIT_BUDGET_RESET = 24'hFFFFFF;

    // Clamp bounds: cell*16*82/100 = cell*328/25, cell*16*118/100 = cell*472/25
    localparam int CLAMP_LO_PCT = 82;
    localparam int CLAMP_HI_PCT = 118;
    localparam int PCT_DIV      = 100;
    localparam int LO_MUL       = (16 * CLAMP_LO_PCT) / 4;
    localparam int HI_MUL       = (16 * CLAMP_HI_PCT) / 4;
    localparam int BOUND_DIV    = PCT_DIV / 4;
    localparam int Y_W          = 19;
    localparam int RECIP_SHIFT  = 24;
    localparam int RECIP_W      = 20;
    localparam longint RECIP_MUL =
        ((longint'(1) << RECIP_SHIFT) + BOUND_DIV - 1) / BOUND_DIV;

    // Divider: two quotient bits per cycle
    localparam int DIV_RADIX = 2;
    localparam int DIV_STEPS = QUOT_W / DIV_RADIX;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CELL_TIME  = 1'b0,
        REG_BIT_BUDGET = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic check;
        logic div_step;
        logic limit;
        logic sub;
        logic update;
        logic emit;
    } fdsp_cmd_t;

    typedef struct packed {
        logic exhausted;
    } fdsp_sts_t;

endpackage

### hdl/fdsp_if.sv
// ----------------------------------------------------------------------------
// fdsp_if
// Channel interfaces: flux intervals in, bit runs out, register writes in.
// ----------------------------------------------------------------------------
interface fdsp_flux_if;
    logic                        valid;
    logic                        ready;
    logic [fdsp_pkg::FLUX_W-1:0] flux_interval;
    logic                        start_pass;

    modport source (output valid, output flux_interval, output start_pass, input ready);
    modport sink (input valid, input flux_interval, input start_pass, output ready);
endinterface

interface fdsp_bits_if;
    logic                          valid;
    logic                          ready;
    logic [fdsp_pkg::ZRUN_W-1:0]   zero_run;
    logic                          one_emitted;
    logic                          budget_reached;
    logic [fdsp_pkg::PERIOD_W-1:0] period_now;

    modport source (output valid, output zero_run, output one_emitted,
                    output budget_reached, output period_now, input ready);
    modport sink (input valid, input zero_run, input one_emitted,
                  input budget_reached, input period_now, output ready);
endinterface

interface fdsp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fdsp_pkg::CFG_IDX_W-1:0] index;
    logic [fdsp_pkg::BUDGET_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/fdsp_ctrl.sv
// ----------------------------------------------------------------------------
// fdsp_ctrl
// Sequencer for one flux word: prepare, divide, limit, correct, emit.
// ----------------------------------------------------------------------------
module fdsp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  fdsp_pkg::fdsp_sts_t sts,
    output fdsp_pkg::fdsp_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_PREP   = 8'b0000_0010,
        S_CHECK  = 8'b0000_0100,
        S_DIV    = 8'b0000_1000,
        S_LIMIT  = 8'b0001_0000,
        S_SUB    = 8'b0010_0000,
        S_UPDATE = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } state_t;

    localparam logic [fdsp_pkg::DIV_CNT_W-1:0] CNT_LAST =
        fdsp_pkg::DIV_CNT_W'(fdsp_pkg::DIV_STEPS - 1);

    state_t                           state_reg;
    state_t                           state_next;
    logic [fdsp_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [fdsp_pkg::DIV_CNT_W-1:0]   cnt_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             in_fire;
    logic                             slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:   state_next = S_CHECK;
            S_CHECK:  state_next = sts.exhausted ? S_EMIT : S_DIV;
            S_DIV:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_LIMIT;
                end
            end
            S_LIMIT:  state_next = S_SUB;
            S_SUB:    state_next = S_UPDATE;
            S_UPDATE: state_next = S_EMIT;
            S_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.load     = in_fire;
        cmd.prep     = (state_reg == S_PREP);
        cmd.check    = (state_reg == S_CHECK);
        cmd.div_step = (state_reg == S_DIV);
        cmd.limit    = (state_reg == S_LIMIT);
        cmd.sub      = (state_reg == S_SUB);
        cmd.update   = (state_reg == S_UPDATE);
        cmd.emit     = (state_reg == S_EMIT) && slot_free;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (state_reg == S_CHECK)
        begin
            cnt_next = '0;
        end
        else if (state_reg == S_DIV)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    // hold the result word until taken; a new one may load on the same edge
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_PREP)
        else $error("accepted word did not start preparation");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) && (cnt_reg == CNT_LAST) |=> state_reg == S_LIMIT)
        else $error("divider did not finish after the last step");

    a_skip_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) && sts.exhausted |=> state_reg == S_EMIT)
        else $error("exhausted budget did not skip to emit");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("emitted word not presented");

endmodule

### hdl/fdsp_datapath.sv
// ----------------------------------------------------------------------------
// fdsp_datapath
// Phase, period and bit count state, radix-4 divider, period correction.
// ----------------------------------------------------------------------------
module fdsp_datapath #(
    parameter int BIT_COUNT_WIDTH = fdsp_pkg::BIT_COUNT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fdsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fdsp_pkg::BUDGET_W-1:0]   cfg_data,
    input  logic [fdsp_pkg::FLUX_W-1:0]     flux_interval,
    input  logic                            start_pass,
    input  fdsp_pkg::fdsp_cmd_t             cmd,
    output fdsp_pkg::fdsp_sts_t             sts,
    output logic [fdsp_pkg::ZRUN_W-1:0]     zero_run,
    output logic                            one_emitted,
    output logic                            budget_reached,
    output logic [fdsp_pkg::PERIOD_W-1:0]   period_now
);

    localparam int CW      = BIT_COUNT_WIDTH;
    localparam int BW      = (CW > fdsp_pkg::BUDGET_W) ? CW : fdsp_pkg::BUDGET_W;
    localparam int PW      = fdsp_pkg::PERIOD_W;
    localparam int QW      = fdsp_pkg::QUOT_W;
    localparam int POSW    = fdsp_pkg::POS_W;
    localparam int ERR_W   = fdsp_pkg::POS_W + 2;
    localparam int YW      = fdsp_pkg::Y_W;
    localparam int BPROD_W = fdsp_pkg::Y_W + fdsp_pkg::RECIP_W;
    localparam int KPROD_W = fdsp_pkg::QUOT_W + fdsp_pkg::PERIOD_W;
    localparam logic [BW-1:0] COUNT_MAX = BW'({CW{1'b1}});

    // configuration
    logic [fdsp_pkg::CELL_W-1:0]   cell_time_reg;
    logic [fdsp_pkg::BUDGET_W-1:0] bit_budget_reg;

    // loop state
    logic [fdsp_pkg::PHASE_W-1:0]  phase_reg;
    logic [PW-1:0]                 period_reg;
    logic [CW-1:0]                 bits_reg;

    // per-word working registers
    logic [fdsp_pkg::FLUX_W-1:0]   flux_reg;
    logic                          start_reg;
    logic [POSW-1:0]               pos_reg;
    logic [QW-1:0]                 dvd_reg;
    logic [PW-1:0]                 rem_reg;
    logic [CW-1:0]                 remaining_reg;
    logic [QW-1:0]                 k_reg;
    logic                          one_reg;

    // clamp bound pipeline
    logic [YW-1:0]                 ylo_reg;
    logic [YW-1:0]                 yhi_reg;
    logic [PW-1:0]                 lo_reg;
    logic [PW-1:0]                 hi_reg;

    // result word
    logic [fdsp_pkg::ZRUN_W-1:0]   zero_run_reg;
    logic                          one_out_reg;
    logic                          reached_reg;
    logic [PW-1:0]                 period_out_reg;

    logic [fdsp_pkg::CELL_W-1:0]   eff_cell;
    logic [PW-1:0]                 period_init;
    logic [BW-1:0]                 budget_wide;
    logic [CW-1:0]                 budget_eff;
    logic [fdsp_pkg::PHASE_W-1:0]  phase_sel;
    logic [PW-1:0]                 period_sel;
    logic [CW-1:0]                 bits_sel;
    logic [POSW-1:0]               pos_next;
    logic [QW-1:0]                 dvd_load;
    logic [QW-1:0]                 dvd_next;
    logic [PW-1:0]                 rem_next;
    logic [QW-1:0]                 k_next;
    logic [KPROD_W-1:0]            k_prod;
    logic [BPROD_W-1:0]            lo_prod;
    logic [BPROD_W-1:0]            hi_prod;
    logic                          one_next;
    logic signed [ERR_W-1:0]       err;
    logic signed [ERR_W-1:0]       err_shr;
    logic signed [ERR_W-1:0]       err_fix;
    logic signed [ERR_W-1:0]       np;
    logic signed [ERR_W-1:0]       lo_s;
    logic signed [ERR_W-1:0]       hi_s;
    logic [PW-1:0]                 period_next;

    // a zero cell time acts as one tick
    assign eff_cell    = (cell_time_reg == '0) ? fdsp_pkg::CELL_W'(1) : cell_time_reg;
    assign period_init = PW'({eff_cell, {fdsp_pkg::SCALE_SHIFT{1'b0}}});

    assign budget_wide = BW'(bit_budget_reg);
    assign budget_eff  = (budget_wide > COUNT_MAX) ? CW'(COUNT_MAX) : CW'(budget_wide);

    assign phase_sel  = start_reg ? '0 : phase_reg;
    assign period_sel = start_reg ? period_init : period_reg;
    assign bits_sel   = start_reg ? '0 : bits_reg;
    assign pos_next   = POSW'(phase_sel)
                      + POSW'({flux_reg, {fdsp_pkg::SCALE_SHIFT{1'b0}}});

    assign sts.exhausted = (bits_reg >= budget_eff);

    // zeros to emit: (pos - 1) / period when pos overshoots the period
    assign dvd_load = (pos_reg > POSW'(period_reg)) ? QW'(pos_reg - POSW'(1)) : '0;

    always_comb
    begin : div_step
        logic [PW-1:0] r;
        logic [QW-1:0] d;
        logic [PW:0]   trial;
        r = rem_reg;
        d = dvd_reg;
        for (int i = 0; i < fdsp_pkg::DIV_RADIX; i++)
        begin
            trial = {r, d[QW-1]};
            d     = {d[QW-2:0], 1'b0};
            if (trial >= {1'b0, period_reg})
            begin
                r    = PW'(trial - {1'b0, period_reg});
                d[0] = 1'b1;
            end
            else
            begin
                r = trial[PW-1:0];
            end
        end
        rem_next = r;
        dvd_next = d;
    end

    // stop the zero run at the budget
    assign k_next = (BW'(dvd_reg) > BW'(remaining_reg)) ? QW'(remaining_reg) : dvd_reg;
    assign k_prod = KPROD_W'(k_reg) * KPROD_W'(period_reg);

    // period += (pos - period/2) / 4, truncating toward zero, then clamp
    assign one_next = (bits_reg < budget_eff);
    assign err      = signed'(ERR_W'(pos_reg)) - signed'(ERR_W'(period_reg >> 1));
    assign err_shr  = err >>> fdsp_pkg::GAIN_SHIFT;
    assign err_fix  = (err[ERR_W-1] && (err[fdsp_pkg::GAIN_SHIFT-1:0] != '0))
                    ? ERR_W'(1) : '0;
    assign np       = signed'(ERR_W'(period_reg)) + err_shr + err_fix;
    assign lo_s     = signed'(ERR_W'(lo_reg));
    assign hi_s     = signed'(ERR_W'(hi_reg));

    always_comb
    begin
        if (np < lo_s)
        begin
            period_next = lo_reg;
        end
        else if (np > hi_s)
        begin
            period_next = hi_reg;
        end
        else
        begin
            period_next = np[PW-1:0];
        end
    end

    assign lo_prod = BPROD_W'(ylo_reg) * BPROD_W'(fdsp_pkg::RECIP_MUL);
    assign hi_prod = BPROD_W'(yhi_reg) * BPROD_W'(fdsp_pkg::RECIP_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_time_reg  <= fdsp_pkg::CELL_TIME_RESET;
            bit_budget_reg <= fdsp_pkg::BIT_BUDGET_RESET;
        end
        else if (cfg_we)
        begin
            case (fdsp_pkg::cfg_reg_t'(cfg_index))
                fdsp_pkg::REG_CELL_TIME:  cell_time_reg  <= cfg_data[fdsp_pkg::CELL_W-1:0];
                fdsp_pkg::REG_BIT_BUDGET: bit_budget_reg <= cfg_data;
                default:                  cell_time_reg  <= cell_time_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            period_reg <= PW'({fdsp_pkg::CELL_TIME_RESET, {fdsp_pkg::SCALE_SHIFT{1'b0}}});
            bits_reg   <= '0;
        end
        else if (cmd.prep)
        begin
            phase_reg  <= phase_sel;
            period_reg <= period_sel;
            bits_reg   <= bits_sel;
        end
        else if (cmd.sub)
        begin
            bits_reg <= bits_reg + CW'(k_reg);
        end
        else if (cmd.update)
        begin
            phase_reg  <= pos_reg[fdsp_pkg::PHASE_W-1:0];
            period_reg <= period_next;
            bits_reg   <= bits_reg + CW'(one_next);
        end
    end

    always_ff @(posedge clk)
    begin
        ylo_reg <= YW'(eff_cell) * YW'(fdsp_pkg::LO_MUL);
        yhi_reg <= YW'(eff_cell) * YW'(fdsp_pkg::HI_MUL);
        lo_reg  <= PW'(lo_prod >> fdsp_pkg::RECIP_SHIFT);
        hi_reg  <= PW'(hi_prod >> fdsp_pkg::RECIP_SHIFT);

        if (cmd.load)
        begin
            flux_reg  <= flux_interval;
            start_reg <= start_pass;
        end
        if (cmd.prep)
        begin
            pos_reg <= pos_next;
        end
        if (cmd.check)
        begin
            dvd_reg       <= dvd_load;
            rem_reg       <= '0;
            remaining_reg <= budget_eff - bits_reg;
            k_reg         <= '0;
            one_reg       <= 1'b0;
        end
        if (cmd.div_step)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
        if (cmd.limit)
        begin
            k_reg <= k_next;
        end
        if (cmd.sub)
        begin
            pos_reg <= pos_reg - POSW'(k_prod);
        end
        if (cmd.update)
        begin
            one_reg <= one_next;
        end
        if (cmd.emit)
        begin
            zero_run_reg   <= k_reg[fdsp_pkg::ZRUN_W-1:0];
            one_out_reg    <= one_reg;
            reached_reg    <= (bits_reg >= budget_eff);
            period_out_reg <= period_reg;
        end
    end

    assign zero_run       = zero_run_reg;
    assign one_emitted    = one_out_reg;
    assign budget_reached = reached_reg;
    assign period_now     = period_out_reg;

    a_period_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> (period_reg >= lo_reg) && (period_reg <= hi_reg))
        else $error("corrected period outside clamp bounds");

    a_count_in_budget: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> bits_reg <= budget_eff)
        else $error("bit count passed the budget");

endmodule

### hdl/flux_data_separator_pll_core.sv
// ----------------------------------------------------------------------------
// flux_data_separator_pll_core
// Adaptive digital PLL data separator: flux intervals in, zero runs out.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                         | accept
//  flux    | in  | flux_interval[15:0], start_pass                 | valid & ready
//  bits    | out | zero_run[16:0], one_emitted, budget_reached,    | valid & ready
//          |     | period_now[14:0]                                |
//  cfg     | in  | index[0], data[23:0]                            | valid & ready
//
//  A flux word runs through prepare, check, the 12-step radix-4 divider that
//  counts the zero cells, limit, sub, update and emit; a word arriving with the
//  budget spent skips from check to emit. One word is in work at a time.
//  A result waits in an output register; the next flux word is taken while it
//  waits, and the block holds at emit only while that register is still full.
//  Reset clears phase and bit count, loads the period from the reset cell time.
//  cfg is always ready.
// ----------------------------------------------------------------------------
module flux_data_separator_pll_core #(
    parameter int BIT_COUNT_WIDTH = fdsp_pkg::BIT_COUNT_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    fdsp_flux_if.sink   flux,
    fdsp_bits_if.source bits,
    fdsp_cfg_if.sink    cfg
);

    fdsp_pkg::fdsp_cmd_t cmd;
    fdsp_pkg::fdsp_sts_t sts;
    logic                cfg_we;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    fdsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (flux.valid),
        .in_ready  (flux.ready),
        .out_valid (bits.valid),
        .out_ready (bits.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    fdsp_datapath #(
        .BIT_COUNT_WIDTH (BIT_COUNT_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .flux_interval  (flux.flux_interval),
        .start_pass     (flux.start_pass),
        .cmd            (cmd),
        .sts            (sts),
        .zero_run       (bits.zero_run),
        .one_emitted    (bits.one_emitted),
        .budget_reached (bits.budget_reached),
        .period_now     (bits.period_now)
    );

endmodule
